FILE: sv/pdbp_pkg.sv
// Package with the types, card images, glyph patterns and codes of the banner parser.
package pdbp_pkg;

  localparam int CARD_COLUMNS_DEF        = 80;
  localparam int GLYPH_PATTERN_COUNT_DEF = 45;
  localparam int GLYPH_SLOTS_DEF         = 22;
  localparam int SLOTS_PER_BAND          = 11;
  localparam int PATTERN_TABLE           = 64;
  localparam logic [4:0] GLYPH_MASK      = 5'h1F;
  localparam logic [6:0] SPACE_CHAR      = 7'h20;

  // Deck state codes as they appear on the next-state output.
  localparam logic [2:0] DS_IDLE     = 3'd0;
  localparam logic [2:0] DS_START    = 3'd1;
  localparam logic [2:0] DS_SCAN     = 3'd2;
  localparam logic [2:0] DS_HDR_END  = 3'd3;
  localparam logic [2:0] DS_CACHE    = 3'd4;
  localparam logic [2:0] DS_DECK_END = 3'd5;

  localparam logic [1:0] CLS_ORDINARY = 2'd0;
  localparam logic [1:0] CLS_BANNER   = 2'd1;
  localparam logic [1:0] CLS_DECK_END = 2'd2;

  localparam logic [1:0] DEST_BANNER  = 2'd0;
  localparam logic [1:0] DEST_DATA    = 2'd1;
  localparam logic [1:0] DEST_TRAILER = 2'd2;
  localparam logic [1:0] DEST_NONE    = 2'd3;

  localparam logic [0:0] KIND_DISP  = 1'b0;
  localparam logic [0:0] KIND_GLYPH = 1'b1;

  typedef logic [24:0] glyph_img_t;

  // Banner card image, one column per index.
  function automatic logic [11:0] banner_col(input logic [6:0] i);
    logic [11:0] v;
    v = 12'o0;
    case (i)
      7'd0, 7'd79: v = 12'o0005;
      7'd3, 7'd7, 7'd17, 7'd21, 7'd31, 7'd35, 7'd45, 7'd49, 7'd59, 7'd63, 7'd73,
      7'd77: v = 12'o7700;
      7'd4, 7'd5, 7'd6, 7'd18, 7'd19, 7'd20, 7'd32, 7'd33, 7'd34, 7'd46, 7'd47,
      7'd48, 7'd60, 7'd61, 7'd62, 7'd74, 7'd75, 7'd76: v = 12'o7704;
      7'd10, 7'd14, 7'd24, 7'd28, 7'd38, 7'd42, 7'd52, 7'd56, 7'd66,
      7'd70: v = 12'o0077;
      7'd11, 7'd12, 7'd13, 7'd25, 7'd26, 7'd27, 7'd39, 7'd40, 7'd41, 7'd53, 7'd54,
      7'd55, 7'd67, 7'd68, 7'd69: v = 12'o0477;
      default: v = 12'o0;
    endcase
    return v;
  endfunction

  // End-of-deck card image.
  function automatic logic [11:0] deck_end_col(input logic [6:0] i);
    logic [11:0] v;
    v = 12'o0;
    case (i)
      7'd0, 7'd79: v = 12'o0005;
      7'd17: v = 12'o2000;
      7'd18, 7'd19, 7'd20: v = 12'o2400;
      7'd21: v = 12'o3700;
      7'd24: v = 12'o3721;
      7'd25: v = 12'o2112;
      7'd26, 7'd27: v = 12'o2104;
      7'd28, 7'd42, 7'd49: v = 12'o3737;
      7'd31, 7'd32, 7'd33, 7'd34: v = 12'o0021;
      7'd35: v = 12'o0037;
      7'd38: v = 12'o1621;
      7'd39, 7'd40, 7'd41: v = 12'o2125;
      7'd45: v = 12'o3716;
      7'd46: v = 12'o0221;
      7'd47: v = 12'o0421;
      7'd48: v = 12'o1021;
      7'd52: v = 12'o2100;
      7'd53, 7'd54, 7'd55: v = 12'o2500;
      7'd56: v = 12'o3700;
      default: v = 12'o0;
    endcase
    return v;
  endfunction

  // Lace glyph patterns, first row in the top five bits.
  function automatic glyph_img_t lace_pattern(input logic [5:0] p);
    glyph_img_t v;
    v = '1;
    case (p)
      6'd0:  v = {5'o37, 5'o37, 5'o37, 5'o37, 5'o37};
      6'd1:  v = {5'o00, 5'o00, 5'o00, 5'o00, 5'o00};
      6'd2:  v = {5'o00, 5'o03, 5'o03, 5'o03, 5'o00};
      6'd3:  v = {5'o21, 5'o00, 5'o12, 5'o00, 5'o04};
      6'd4:  v = {5'o37, 5'o24, 5'o24, 5'o24, 5'o37};
      6'd5:  v = {5'o37, 5'o25, 5'o25, 5'o25, 5'o12};
      6'd6:  v = {5'o37, 5'o21, 5'o21, 5'o21, 5'o21};
      6'd7:  v = {5'o37, 5'o21, 5'o21, 5'o21, 5'o16};
      6'd8:  v = {5'o37, 5'o25, 5'o25, 5'o25, 5'o21};
      6'd9:  v = {5'o37, 5'o24, 5'o24, 5'o24, 5'o20};
      6'd10: v = {5'o37, 5'o21, 5'o21, 5'o25, 5'o27};
      6'd11: v = {5'o37, 5'o04, 5'o04, 5'o04, 5'o37};
      6'd12: v = {5'o21, 5'o21, 5'o37, 5'o21, 5'o21};
      6'd13: v = {5'o03, 5'o01, 5'o01, 5'o01, 5'o37};
      6'd14: v = {5'o37, 5'o04, 5'o04, 5'o12, 5'o21};
      6'd15: v = {5'o37, 5'o01, 5'o01, 5'o01, 5'o01};
      6'd16: v = {5'o37, 5'o10, 5'o04, 5'o10, 5'o37};
      6'd17: v = {5'o37, 5'o10, 5'o04, 5'o02, 5'o37};
      6'd18: v = {5'o37, 5'o21, 5'o21, 5'o21, 5'o37};
      6'd19: v = {5'o37, 5'o24, 5'o24, 5'o24, 5'o34};
      6'd20: v = {5'o37, 5'o21, 5'o25, 5'o23, 5'o37};
      6'd21: v = {5'o37, 5'o24, 5'o24, 5'o26, 5'o35};
      6'd22: v = {5'o35, 5'o25, 5'o25, 5'o25, 5'o27};
      6'd23: v = {5'o20, 5'o20, 5'o37, 5'o20, 5'o20};
      6'd24: v = {5'o37, 5'o01, 5'o01, 5'o01, 5'o37};
      6'd25: v = {5'o30, 5'o06, 5'o01, 5'o06, 5'o30};
      6'd26: v = {5'o37, 5'o02, 5'o04, 5'o02, 5'o37};
      6'd27: v = {5'o21, 5'o12, 5'o04, 5'o12, 5'o21};
      6'd28: v = {5'o20, 5'o10, 5'o07, 5'o10, 5'o20};
      6'd29: v = {5'o21, 5'o27, 5'o25, 5'o35, 5'o21};
      6'd30: v = {5'o16, 5'o21, 5'o21, 5'o21, 5'o16};
      6'd31: v = {5'o00, 5'o10, 5'o00, 5'o37, 5'o00};
      6'd32: v = {5'o23, 5'o25, 5'o25, 5'o25, 5'o35};
      6'd33: v = {5'o21, 5'o25, 5'o25, 5'o25, 5'o37};
      6'd34: v = {5'o34, 5'o04, 5'o04, 5'o04, 5'o37};
      6'd35: v = {5'o35, 5'o25, 5'o25, 5'o25, 5'o22};
      6'd36: v = {5'o37, 5'o05, 5'o05, 5'o05, 5'o07};
      6'd37: v = {5'o20, 5'o21, 5'o22, 5'o24, 5'o30};
      6'd38: v = {5'o12, 5'o25, 5'o25, 5'o25, 5'o12};
      6'd39: v = {5'o34, 5'o24, 5'o24, 5'o24, 5'o37};
      6'd40: v = {5'o01, 5'o01, 5'o01, 5'o01, 5'o01};
      6'd41: v = {5'o00, 5'o04, 5'o04, 5'o04, 5'o00};
      6'd42: v = {5'o00, 5'o04, 5'o12, 5'o21, 5'o00};
      6'd43: v = {5'o00, 5'o21, 5'o12, 5'o04, 5'o00};
      6'd44: v = {5'o01, 5'o02, 5'o04, 5'o10, 5'o20};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Character for each lace pattern; entries past the defined set read as NUL.
  function automatic logic [6:0] lace_char(input logic [5:0] p);
    logic [6:0] c;
    c = 7'h00;
    case (p)
      6'd0: c = 7'h2A;
      6'd1: c = 7'h20;
      6'd2: c = 7'h2E;
      6'd3: c = 7'h3E;
      6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26,
      6'd27, 6'd28, 6'd29: c = 7'(7'h41 + 7'(p - 6'd4));
      6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
      6'd39: c = 7'(7'h30 + 7'(p - 6'd30));
      6'd40: c = 7'h5F;
      6'd41: c = 7'h2D;
      6'd42: c = 7'h28;
      6'd43: c = 7'h29;
      6'd44: c = 7'h2F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // First column of each glyph slot within a row band.
  function automatic logic [6:0] band_start(input logic [3:0] b);
    logic [6:0] v;
    v = 7'd3;
    case (b)
      4'd0: v = 7'd73;
      4'd1: v = 7'd66;
      4'd2: v = 7'd59;
      4'd3: v = 7'd52;
      4'd4: v = 7'd45;
      4'd5: v = 7'd38;
      4'd6: v = 7'd31;
      4'd7: v = 7'd24;
      4'd8: v = 7'd17;
      4'd9: v = 7'd10;
      default: v = 7'd3;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/pdbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pdbp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/punched_deck_banner_parser.sv
// Top level of the punched deck banner parser: card store, deck state machine, glyph decode.
// A column that does not end a card is taken without a stall and gives no request.
// A card-ending column that scans glyphs stalls the input while each of the 22 glyph slots is
// read (five column reads), searched over GLYPH_PATTERN_COUNT patterns and emitted (within the
// glyph limit) and while the output stalls; other card ends stall it until the disposition is sent.
// Synchronous active-low reset returns to idle with a glyph limit of 1023; memory not cleared.
module punched_deck_banner_parser
  import pdbp_pkg::*;
#(
  parameter int GLYPH_PATTERN_COUNT = GLYPH_PATTERN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_column_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [6:0]  out_glyph_char,
  output logic        out_unknown_glyph,
  output logic [1:0]  out_card_class,
  output logic [1:0]  out_destination,
  output logic [2:0]  out_next_state,
  output logic        out_job_done,
  output logic        out_unexpected_card,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_glyph_limit
);

  localparam int PW = (GLYPH_PATTERN_COUNT > 1) ? $clog2(GLYPH_PATTERN_COUNT) : 1;
  localparam logic [PW:0] PAT_LAST = (PW + 1)'(GLYPH_PATTERN_COUNT - 1);

  typedef enum logic [4:0] {
    S_COL   = 5'b00001,
    S_READ  = 5'b00010,
    S_MATCH = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DISP  = 5'b10000
  } fsm_t;

  fsm_t        st_r, st_nxt;
  logic [6:0]  col_idx_r, col_idx_nxt;
  logic [2:0]  deck_r, deck_nxt;
  logic [9:0]  gcount_r, gcount_nxt;
  logic        ban_r, ban_nxt, dend_r, dend_nxt;
  logic [9:0]  limit_r;
  logic [4:0]  slot_r, slot_nxt;
  logic [2:0]  k_r, k_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  glyph_img_t  img_r, img_nxt;
  logic [PW:0] pat_r, pat_nxt;
  logic        found_r, found_nxt;
  logic [6:0]  ch_r, ch_nxt;
  logic [1:0]  cls_r, cls_nxt;
  logic [1:0]  dest_r, dest_nxt;
  logic        done_r, done_nxt, unexp_r, unexp_nxt;

  logic        ov_r, ov_nxt;
  logic        o_kind_r, o_kind_nxt, o_unk_r, o_unk_nxt, o_last_r, o_last_nxt;
  logic [6:0]  o_ch_r, o_ch_nxt;
  logic [1:0]  o_cls_r, o_cls_nxt, o_dest_r, o_dest_nxt;
  logic [2:0]  o_state_r, o_state_nxt;
  logic        o_done_r, o_done_nxt, o_unexp_r, o_unexp_nxt;

  logic        in_acc, out_free, card_end, ban_now, dend_now;
  logic [11:0] rd_data;
  logic [6:0]  rd_addr, start_col, colsum;
  logic [3:0]  band_slot;
  logic [4:0]  rd_bits;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = !(st_r == S_COL);
  assign cfg_ready = (st_r == S_COL);
  assign card_end = (col_idx_r == 7'(CARD_COLUMNS_DEF - 1));
  assign ban_now  = ban_r && (in_column_bits == banner_col(col_idx_r));
  assign dend_now = dend_r && (in_column_bits == deck_end_col(col_idx_r));

  // Column address of the current glyph row: columns are read mirrored.
  assign band_slot = (slot_r < 5'(SLOTS_PER_BAND)) ? slot_r[3:0]
                                                   : 4'(slot_r - 5'(SLOTS_PER_BAND));
  assign start_col = band_start(band_slot);
  assign colsum    = 7'(start_col + 7'd4 - 7'(k_r));
  assign rd_addr   = (colsum >= 7'(CARD_COLUMNS_DEF)) ? 7'(colsum - 7'(CARD_COLUMNS_DEF))
                                                      : colsum;
  assign rd_bits   = (slot_r < 5'(SLOTS_PER_BAND)) ? rd_data[10:6] & GLYPH_MASK
                                                   : rd_data[4:0] & GLYPH_MASK;

  pdbp_ram #(.WIDTH(12), .DEPTH(CARD_COLUMNS_DEF)) u_cards (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_idx_r),
    .wr_data (in_column_bits),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: column intake, glyph reads, search and glyph requests, then the disposition request.
  always_comb begin
    st_nxt = st_r; col_idx_nxt = col_idx_r; deck_nxt = deck_r; gcount_nxt = gcount_r;
    ban_nxt = ban_r; dend_nxt = dend_r; slot_nxt = slot_r; k_nxt = k_r;
    rd_pend_nxt = 1'b0; img_nxt = img_r; pat_nxt = pat_r; found_nxt = found_r;
    ch_nxt = ch_r; cls_nxt = cls_r; dest_nxt = dest_r; done_nxt = done_r;
    unexp_nxt = unexp_r;
    ov_nxt = ov_r && out_stall; o_kind_nxt = o_kind_r; o_unk_nxt = o_unk_r;
    o_last_nxt = o_last_r; o_ch_nxt = o_ch_r;
    o_cls_nxt = o_cls_r; o_dest_nxt = o_dest_r; o_state_nxt = o_state_r;
    o_done_nxt = o_done_r; o_unexp_nxt = o_unexp_r;
    case (st_r)
      S_COL: begin
        if (in_acc) begin
          if (!card_end) begin
            col_idx_nxt = 7'(col_idx_r + 7'd1);
            ban_nxt = ban_now;
            dend_nxt = dend_now;
          end else begin
            col_idx_nxt = '0;
            ban_nxt = 1'b1;
            dend_nxt = 1'b1;
            cls_nxt = ban_now ? CLS_BANNER : (dend_now ? CLS_DECK_END : CLS_ORDINARY);
            dest_nxt = DEST_NONE; done_nxt = 1'b0; unexp_nxt = 1'b0;
            st_nxt = S_DISP;
            if (ban_now) begin
              case (deck_r)
                DS_IDLE: begin
                  deck_nxt = DS_START; dest_nxt = DEST_BANNER; gcount_nxt = '0;
                end
                DS_SCAN: begin
                  deck_nxt = DS_HDR_END; dest_nxt = DEST_BANNER;
                end
                DS_DECK_END: begin
                  deck_nxt = DS_IDLE; done_nxt = 1'b1;
                end
                default: unexp_nxt = 1'b1;
              endcase
            end else if (dend_now) begin
              if (deck_r != DS_IDLE) begin
                deck_nxt = DS_DECK_END; dest_nxt = DEST_TRAILER;
              end else begin
                unexp_nxt = 1'b1;
              end
            end else begin
              case (deck_r)
                DS_START, DS_SCAN: begin
                  deck_nxt = DS_SCAN; dest_nxt = DEST_BANNER;
                  st_nxt = S_READ; slot_nxt = '0; k_nxt = '0;
                end
                DS_HDR_END, DS_CACHE, DS_DECK_END: begin
                  deck_nxt = DS_CACHE; dest_nxt = DEST_DATA;
                end
                default: unexp_nxt = 1'b1;
              endcase
            end
          end
        end
      end
      S_READ: begin
        // Address for row k is presented now; data returns next cycle.
        if (rd_pend_r) begin
          img_nxt = {img_r[19:0], rd_bits};
        end
        if (k_r != 3'd5) begin
          k_nxt = 3'(k_r + 3'd1);
          rd_pend_nxt = 1'b1;
        end else begin
          st_nxt = S_MATCH; pat_nxt = '0; found_nxt = 1'b0; ch_nxt = SPACE_CHAR;
        end
      end
      S_MATCH: begin
        if (!found_r && img_r == lace_pattern(6'(pat_r))) begin
          found_nxt = 1'b1;
          ch_nxt = lace_char(6'(pat_r)) & 7'h7F;
        end
        if (pat_r == PAT_LAST) begin
          st_nxt = S_EMIT;
        end else begin
          pat_nxt = (PW + 1)'(pat_r + 1'b1);
        end
      end
      S_EMIT: begin
        if (gcount_r >= limit_r || out_free) begin
          if (gcount_r < limit_r) begin
            gcount_nxt = 10'(gcount_r + 10'd1);
            ov_nxt = 1'b1; o_kind_nxt = KIND_GLYPH; o_ch_nxt = ch_r;
            o_unk_nxt = !found_r; o_last_nxt = 1'b0;
            o_cls_nxt = '0; o_dest_nxt = '0; o_state_nxt = '0;
            o_done_nxt = 1'b0; o_unexp_nxt = 1'b0;
          end
          if (slot_r == 5'(GLYPH_SLOTS_DEF - 1)) begin
            st_nxt = S_DISP;
          end else begin
            slot_nxt = 5'(slot_r + 5'd1); k_nxt = '0; st_nxt = S_READ;
          end
        end
      end
      S_DISP: begin
        // The card's fields are copied out so a later card cannot disturb a waiting request.
        if (out_free) begin
          ov_nxt = 1'b1; o_kind_nxt = KIND_DISP; o_ch_nxt = '0; o_unk_nxt = 1'b0;
          o_last_nxt = 1'b1; st_nxt = S_COL;
          o_cls_nxt = cls_r; o_dest_nxt = dest_r; o_state_nxt = deck_r;
          o_done_nxt = done_r; o_unexp_nxt = unexp_r;
        end
      end
      default: st_nxt = S_COL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_COL; col_idx_r <= '0; deck_r <= DS_IDLE; gcount_r <= '0;
      ban_r <= 1'b1; dend_r <= 1'b1; limit_r <= 10'd1023; ov_r <= 1'b0;
      rd_pend_r <= 1'b0; k_r <= '0; slot_r <= '0;
    end else begin
      st_r <= st_nxt; col_idx_r <= col_idx_nxt; deck_r <= deck_nxt;
      gcount_r <= gcount_nxt; ban_r <= ban_nxt; dend_r <= dend_nxt; ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt; k_r <= k_nxt; slot_r <= slot_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_glyph_limit;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    img_r <= img_nxt; pat_r <= pat_nxt; found_r <= found_nxt; ch_r <= ch_nxt;
    cls_r <= cls_nxt; dest_r <= dest_nxt; done_r <= done_nxt; unexp_r <= unexp_nxt;
    o_kind_r <= o_kind_nxt; o_ch_r <= o_ch_nxt; o_unk_r <= o_unk_nxt;
    o_last_r <= o_last_nxt;
    o_cls_r <= o_cls_nxt; o_dest_r <= o_dest_nxt; o_state_r <= o_state_nxt;
    o_done_r <= o_done_nxt; o_unexp_r <= o_unexp_nxt;
  end

  assign out_valid           = ov_r;
  assign out_record_kind     = o_kind_r;
  assign out_glyph_char      = o_ch_r;
  assign out_unknown_glyph   = o_unk_r;
  assign out_card_class      = o_cls_r;
  assign out_destination     = o_dest_r;
  assign out_next_state      = o_state_r;
  assign out_job_done        = o_done_r;
  assign out_unexpected_card = o_unexp_r;
  assign out_last            = o_last_r;

`ifndef NO_ASSERTIONS
  // The glyph count never grows past the limit during a job.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) && $past(st_r == S_EMIT) |-> gcount_r <= limit_r || $stable(gcount_r))
    else $error("glyph count grew past limit");
  // A disposition request always carries last and no glyph fields.
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !o_kind_r |-> o_last_r && !o_unk_r)
    else $error("malformed disposition request");
  // Input is only taken while the card intake stage is active.
  a_intake: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> st_r == S_COL)
    else $error("column taken during decode");
`endif

endmodule

FILE: verif/punched_deck_banner_parser_tb.sv
// Self-checking testbench for the punched deck banner parser: card columns in, requests out.
module punched_deck_banner_parser_tb;
  import pdbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic       kind;
    logic [6:0] char_code;
    logic       unknown;
    logic [1:0] card_class;
    logic [1:0] dest;
    logic [2:0] state;
    logic       done;
    logic       unexp;
    logic       last;
  } parse_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_column_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_kind;
  logic [6:0]  out_glyph_char;
  logic        out_unknown_glyph;
  logic [1:0]  out_card_class;
  logic [1:0]  out_destination;
  logic [2:0]  out_next_state;
  logic        out_job_done;
  logic        out_unexpected_card;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_glyph_limit = '0;

  punched_deck_banner_parser u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic [11:0] card_cols [80];
  int unsigned col_pos = 0;
  logic [2:0]  deck_st = DS_IDLE;
  int unsigned glyphs_sent = 0;
  int unsigned glyph_cap = 1023;
  bit          is_banner = 1, is_deck_end = 1;

  logic [11:0]  column_queue [$];
  parse_item_t  expected_items [$];
  int           errors = 0;
  int           columns_taken = 0;
  int           items_seen = 0;
  int           glyphs_seen = 0;
  int           hold_off = 0;

  // Reference glyph tables (independent copy of the lace set).
  logic [24:0] glyph_shapes [45] = '{
    {5'o37,5'o37,5'o37,5'o37,5'o37}, {5'o00,5'o00,5'o00,5'o00,5'o00},
    {5'o00,5'o03,5'o03,5'o03,5'o00}, {5'o21,5'o00,5'o12,5'o00,5'o04},
    {5'o37,5'o24,5'o24,5'o24,5'o37}, {5'o37,5'o25,5'o25,5'o25,5'o12},
    {5'o37,5'o21,5'o21,5'o21,5'o21}, {5'o37,5'o21,5'o21,5'o21,5'o16},
    {5'o37,5'o25,5'o25,5'o25,5'o21}, {5'o37,5'o24,5'o24,5'o24,5'o20},
    {5'o37,5'o21,5'o21,5'o25,5'o27}, {5'o37,5'o04,5'o04,5'o04,5'o37},
    {5'o21,5'o21,5'o37,5'o21,5'o21}, {5'o03,5'o01,5'o01,5'o01,5'o37},
    {5'o37,5'o04,5'o04,5'o12,5'o21}, {5'o37,5'o01,5'o01,5'o01,5'o01},
    {5'o37,5'o10,5'o04,5'o10,5'o37}, {5'o37,5'o10,5'o04,5'o02,5'o37},
    {5'o37,5'o21,5'o21,5'o21,5'o37}, {5'o37,5'o24,5'o24,5'o24,5'o34},
    {5'o37,5'o21,5'o25,5'o23,5'o37}, {5'o37,5'o24,5'o24,5'o26,5'o35},
    {5'o35,5'o25,5'o25,5'o25,5'o27}, {5'o20,5'o20,5'o37,5'o20,5'o20},
    {5'o37,5'o01,5'o01,5'o01,5'o37}, {5'o30,5'o06,5'o01,5'o06,5'o30},
    {5'o37,5'o02,5'o04,5'o02,5'o37}, {5'o21,5'o12,5'o04,5'o12,5'o21},
    {5'o20,5'o10,5'o07,5'o10,5'o20}, {5'o21,5'o27,5'o25,5'o35,5'o21},
    {5'o16,5'o21,5'o21,5'o21,5'o16}, {5'o00,5'o10,5'o00,5'o37,5'o00},
    {5'o23,5'o25,5'o25,5'o25,5'o35}, {5'o21,5'o25,5'o25,5'o25,5'o37},
    {5'o34,5'o04,5'o04,5'o04,5'o37}, {5'o35,5'o25,5'o25,5'o25,5'o22},
    {5'o37,5'o05,5'o05,5'o05,5'o07}, {5'o20,5'o21,5'o22,5'o24,5'o30},
    {5'o12,5'o25,5'o25,5'o25,5'o12}, {5'o34,5'o24,5'o24,5'o24,5'o37},
    {5'o01,5'o01,5'o01,5'o01,5'o01}, {5'o00,5'o04,5'o04,5'o04,5'o00},
    {5'o00,5'o04,5'o12,5'o21,5'o00}, {5'o00,5'o21,5'o12,5'o04,5'o00},
    {5'o01,5'o02,5'o04,5'o10,5'o20}};
  string glyph_text = "* .>ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-()/";
  int slot_first [11] = '{73, 66, 59, 52, 45, 38, 31, 24, 17, 10, 3};

  // Card image columns, as the reader punches them.
  function automatic logic [11:0] banner_image_col(int i);
    int m;
    if (i == 0 || i == 79) return 12'o0005;
    m = (i - 3) % 14;
    if (i < 3 || i > 77) return 12'o0;
    if (m == 0 || m == 4) return 12'o7700;
    if (m >= 1 && m <= 3) return 12'o7704;
    if (m == 7 || m == 11) return 12'o0077;
    if (m >= 8 && m <= 10) return 12'o0477;
    return 12'o0;
  endfunction

  function automatic logic [11:0] deck_end_image_col(int i);
    case (i)
      0, 79: return 12'o0005;
      17: return 12'o2000;
      18, 19, 20: return 12'o2400;
      21, 56: return 12'o3700;
      24: return 12'o3721;
      25: return 12'o2112;
      26, 27: return 12'o2104;
      28, 42, 49: return 12'o3737;
      31, 32, 33, 34: return 12'o0021;
      35: return 12'o0037;
      38: return 12'o1621;
      39, 40, 41: return 12'o2125;
      45: return 12'o3716;
      46: return 12'o0221;
      47: return 12'o0421;
      48: return 12'o1021;
      52: return 12'o2100;
      53, 54, 55: return 12'o2500;
      default: return 12'o0;
    endcase
  endfunction

  // Decode one glyph slot of the stored card into an expected glyph request.
  function automatic parse_item_t decode_glyph_slot(int slot);
    parse_item_t r;
    logic [24:0] img;
    int shift, first;
    shift = (slot < 11) ? 6 : 0;
    first = slot_first[slot % 11];
    r = '0;
    r.kind = KIND_GLYPH;
    for (int k = 0; k < 5; k++)
      img[24 - 5*k -: 5] = 5'(card_cols[(first + 4 - k) % 80] >> shift);
    r.char_code = SPACE_CHAR;
    r.unknown = 1'b1;
    for (int p = 0; p < 45; p++)
      if (r.unknown && glyph_shapes[p] == img) begin
        r.char_code = 7'(glyph_text[p]);
        r.unknown = 1'b0;
      end
    return r;
  endfunction

  // Step the deck model by one accepted column.
  task automatic predict_column(logic [11:0] col);
    parse_item_t d;
    logic [1:0] cls;
    bit scan;
    card_cols[col_pos] = col;
    if (col != banner_image_col(col_pos)) is_banner = 0;
    if (col != deck_end_image_col(col_pos)) is_deck_end = 0;
    if (col_pos < 79) begin
      col_pos++;
      return;
    end
    col_pos = 0;
    cls = is_banner ? CLS_BANNER : (is_deck_end ? CLS_DECK_END : CLS_ORDINARY);
    is_banner = 1;
    is_deck_end = 1;
    d = '0;
    d.kind = KIND_DISP;
    d.card_class = cls;
    d.dest = DEST_NONE;
    d.last = 1'b1;
    scan = 0;
    case (cls)
      CLS_BANNER: begin
        if (deck_st == DS_IDLE) begin
          deck_st = DS_START; d.dest = DEST_BANNER; glyphs_sent = 0;
        end else if (deck_st == DS_SCAN) begin
          deck_st = DS_HDR_END; d.dest = DEST_BANNER;
        end else if (deck_st == DS_DECK_END) begin
          deck_st = DS_IDLE; d.done = 1'b1;
        end else d.unexp = 1'b1;
      end
      CLS_DECK_END: begin
        if (deck_st != DS_IDLE) begin
          deck_st = DS_DECK_END; d.dest = DEST_TRAILER;
        end else d.unexp = 1'b1;
      end
      default: begin
        if (deck_st == DS_START || deck_st == DS_SCAN) begin
          deck_st = DS_SCAN; d.dest = DEST_BANNER; scan = 1;
        end else if (deck_st != DS_IDLE) begin
          deck_st = DS_CACHE; d.dest = DEST_DATA;
        end else d.unexp = 1'b1;
      end
    endcase
    d.state = deck_st;
    if (scan)
      for (int s = 0; s < 22; s++)
        if (glyphs_sent < glyph_cap) begin
          glyphs_sent++;
          expected_items.push_back(decode_glyph_slot(s));
        end
    expected_items.push_back(d);
  endtask

  // Card builders for the stimulus queue.
  task automatic queue_banner();
    for (int i = 0; i < 80; i++) column_queue.push_back(banner_image_col(i));
  endtask

  task automatic queue_deck_end();
    for (int i = 0; i < 80; i++) column_queue.push_back(deck_end_image_col(i));
  endtask

  // Ordinary card: glyph shapes in the slots, mostly known patterns, some noise.
  task automatic queue_glyph_card(bit noisy);
    logic [11:0] c [80];
    logic [24:0] img;
    int first;
    for (int i = 0; i < 80; i++) c[i] = noisy ? 12'($urandom) : '0;
    for (int s = 0; s < 22; s++) begin
      img = ($urandom_range(0, 5) == 0) ? 25'($urandom) : glyph_shapes[$urandom_range(0, 44)];
      first = slot_first[s % 11];
      for (int k = 0; k < 5; k++)
        if (s < 11) c[(first + 4 - k) % 80][10:6] = img[24 - 5*k -: 5];
        else c[(first + 4 - k) % 80][4:0] = img[24 - 5*k -: 5];
    end
    // Keep it from matching an image by marking the second column.
    c[1] = 12'o7777;
    for (int i = 0; i < 80; i++) column_queue.push_back(c[i]);
  endtask

  // Wait until the column queue is drained and all requests have returned.
  task automatic wait_drained();
    while (column_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_items.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // Register write; the limit is taken at an edge where cfg_valid and cfg_ready are both high.
  task automatic write_limit(logic [9:0] lim);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_glyph_limit <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(posedge clk);
    glyph_cap = lim;
    cfg_valid <= 1'b0;
  endtask

  // Stimulus and register phases.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // A limit that lets the first header card through whole and cuts the second short.
    write_limit(10'($urandom_range(23, 40)));
    queue_banner();
    queue_glyph_card(1'b0);
    queue_glyph_card(1'b1);
    queue_deck_end();
    // Hold the receiver off long enough that decoding blocks and the input stalls.
    hold_off = 1500;
    wait_drained();
    // Closing banner after every earlier request has come back.
    queue_banner();
    wait_drained();
    $display("Covered %0d columns and %0d requests (%0d glyphs): one job, a glyph limit hit,",
             columns_taken, items_seen, glyphs_seen);
    $display("a long receiver hold-off that stalled the input, and a pause to drain.");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Column driver with random gaps.
  int gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_column(in_column_bits);
        columns_taken++;
        void'(column_queue.pop_front());
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
      end
      if (!(in_valid && in_stall)) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (column_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_column_bits <= column_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off.
  int stall_left = 0;
  always @(posedge clk) begin
    parse_item_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_record_kind, out_glyph_char, out_unknown_glyph, out_card_class,
             out_destination, out_next_state, out_job_done, out_unexpected_card, out_last};
      items_seen++;
      if (out_record_kind == KIND_GLYPH) glyphs_seen++;
      if (expected_items.size() == 0) begin
        errors++;
        $display("%0t: unexpected request %h", $realtime, got);
      end else begin
        want = expected_items.pop_front();
        if (got != want) begin
          errors++;
          $display("%0t: mismatch expected kind %0d char %h unk %0d cls %0d dst %0d st %0d",
                   $realtime, want.kind, want.char_code, want.unknown, want.card_class,
                   want.dest, want.state);
          $display("%0t:          actual kind %0d char %h unk %0d cls %0d dst %0d st %0d",
                   $realtime, got.kind, got.char_code, got.unknown, got.card_class,
                   got.dest, got.state);
          $display("%0t: done/unexp/last expected %b%b%b actual %b%b%b", $realtime,
                   want.done, want.unexp, want.last, got.done, got.unexp, got.last);
        end
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
                   ($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 0);
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end
endmodule
